// ===== rtl/roulette_sample_perturb_unit_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ROULETTE_SAMPLE_PERTURB_UNIT_MACROS_SVH
`define ROULETTE_SAMPLE_PERTURB_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSP_ASSERT_NOW(label, ante, cons, msg)
`define RSP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/rsp_pkg.sv =====
`default_nettype none

package rsp_pkg;

    localparam int SAMPLES     = 1024;
    localparam int DIMS        = 16;

    localparam int IDX_W       = $clog2(SAMPLES);
    localparam int DIM_W       = $clog2(DIMS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CADDR_W     = IDX_W + DIM_W;
    localparam int COORD_DEPTH = SAMPLES * DIMS;

    localparam int DATA_W      = 32;
    localparam int DRAW_W      = 32;
    localparam int SUM_W       = 48;
    localparam int HALF_W      = SUM_W / 2;
    localparam int MUL_W       = DRAW_W + HALF_W;
    localparam int LOW_W       = MUL_W + 1;
    localparam int PADDR_W     = 3;

    localparam logic signed [DATA_W-1:0] POS_MIN_RST = -32'sd6553600;
    localparam logic signed [DATA_W-1:0] POS_MAX_RST = 32'sd6553600;

    localparam logic [0:0] REG_POS_MIN = 1'b0;
    localparam logic [0:0] REG_POS_MAX = 1'b1;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_DRAW    = 2'd2,
        FUNC_PERTURB = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_ORDER = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/roulette_sample_perturb_unit.sv =====
// result_valid is set from ST_DONE once the output register is free. Coordinate writes, index-0
// and rejected loads and empty draws go straight to ST_DONE; other loads pass ST_LOAD, perturbs
// ST_PERTURB, draws ST_MUL_HI, ST_MUL_LO, ST_SCALE and 0..10 search steps over the running sums.
// one item is in flight at a time; the next is taken the cycle after its result is registered.
// rst_n (async, active low) clears control, loaded count, selected entry and the bounds;
// the memories are not cleared and no clearing pass runs.
`default_nettype none

`include "roulette_sample_perturb_unit_macros.svh"

module roulette_sample_perturb_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               item_valid,
    output      logic                               item_ready,
    input  wire logic [1:0]                         func,
    input  wire logic [rsp_pkg::IDX_W-1:0]          sample_index,
    input  wire logic [rsp_pkg::DIM_W-1:0]          dim_index,
    input  wire logic signed [rsp_pkg::DATA_W-1:0]  value,
    input  wire logic [rsp_pkg::DRAW_W-1:0]         draw,

    output      logic                               result_valid,
    input  wire logic                               result_ready,
    output      logic [rsp_pkg::IDX_W-1:0]          chosen_index,
    output      logic signed [rsp_pkg::DATA_W-1:0]  coord_out,
    output      logic [1:0]                         status,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rsp_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [rsp_pkg::DATA_W-1:0]         pwdata,
    output      logic [rsp_pkg::DATA_W-1:0]         prdata,
    output      logic                               pready
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_LOAD    = 8'b0000_0010,
        ST_MUL_HI  = 8'b0000_0100,
        ST_MUL_LO  = 8'b0000_1000,
        ST_SCALE   = 8'b0001_0000,
        ST_SEARCH  = 8'b0010_0000,
        ST_PERTURB = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [rsp_pkg::CNT_W-1:0]              lc_reg, lc_next;
    logic [rsp_pkg::IDX_W-1:0]              sel_reg, sel_next;
    logic                                   result_valid_reg, result_valid_next;
    logic signed [rsp_pkg::DATA_W-1:0]      pos_min_reg, pos_max_reg;

    // per-item working registers
    logic [rsp_pkg::IDX_W-1:0]              lidx_reg, lidx_next;
    logic signed [rsp_pkg::DATA_W-1:0]      val_reg, val_next;
    logic [rsp_pkg::DRAW_W-1:0]             draw_reg, draw_next;
    logic [rsp_pkg::SUM_W-1:0]              total_reg, total_next;
    logic [rsp_pkg::MUL_W-1:0]              a_reg, a_next;
    logic [rsp_pkg::MUL_W-1:0]              b_reg, b_next;
    logic [rsp_pkg::SUM_W-1:0]              target_reg, target_next;
    logic [rsp_pkg::IDX_W-1:0]              lo_reg, lo_next;
    logic [rsp_pkg::IDX_W-1:0]              hi_reg, hi_next;
    logic [rsp_pkg::IDX_W-1:0]              mid_reg, mid_next;
    rsp_pkg::status_t                       pstat_reg, pstat_next;
    logic signed [rsp_pkg::DATA_W-1:0]      pcoord_reg, pcoord_next;

    // output register
    logic [rsp_pkg::IDX_W-1:0]              res_idx_reg;
    logic signed [rsp_pkg::DATA_W-1:0]      res_coord_reg;
    rsp_pkg::status_t                       res_stat_reg;

    // running-sum memory
    logic [rsp_pkg::SUM_W-1:0]              sums_mem [rsp_pkg::SAMPLES];
    logic                                   sum_we, sum_re;
    logic [rsp_pkg::IDX_W-1:0]              sum_waddr, sum_raddr;
    logic [rsp_pkg::SUM_W-1:0]              sum_wdata;
    logic [rsp_pkg::SUM_W-1:0]              sum_rdata_reg;

    // coordinate memory
    logic [rsp_pkg::DATA_W-1:0]             coord_mem [rsp_pkg::COORD_DEPTH];
    logic                                   coord_we, coord_re;
    logic [rsp_pkg::CADDR_W-1:0]            coord_waddr, coord_raddr;
    logic [rsp_pkg::DATA_W-1:0]             coord_rdata_reg;

    logic                                   item_accept;
    logic                                   cfg_write;
    logic                                   out_free;
    logic [rsp_pkg::CNT_W-1:0]              lc_dec;
    logic [rsp_pkg::LOW_W-1:0]              low_sum;
    logic [rsp_pkg::SUM_W-1:0]              scaled;
    logic                                   ge;
    logic [rsp_pkg::IDX_W-1:0]              lo_step, hi_step, span;
    logic signed [rsp_pkg::DATA_W:0]        c_sum, c_low, c_clamp;

    function automatic logic [rsp_pkg::SUM_W-1:0] weight(
        input logic signed [rsp_pkg::DATA_W-1:0] v
    );
        logic [rsp_pkg::SUM_W-1:0] w;
        if (v > 0)
            w = rsp_pkg::SUM_W'(unsigned'(v));
        else
            w = rsp_pkg::SUM_W'(1);
        return w;
    endfunction

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_accept  = item_valid && item_ready;
    assign out_free     = !result_valid_reg || result_ready;
    assign lc_dec       = lc_reg - rsp_pkg::CNT_W'(1);

    assign result_valid = result_valid_reg;
    assign chosen_index = res_idx_reg;
    assign coord_out    = res_coord_reg;
    assign status       = res_stat_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2:2])
            rsp_pkg::REG_POS_MIN: prdata = pos_min_reg;
            rsp_pkg::REG_POS_MAX: prdata = pos_max_reg;
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_min_reg <= rsp_pkg::POS_MIN_RST;
            pos_max_reg <= rsp_pkg::POS_MAX_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2:2])
                rsp_pkg::REG_POS_MIN: pos_min_reg <= signed'(pwdata);
                rsp_pkg::REG_POS_MAX: pos_max_reg <= signed'(pwdata);
                default:              ;
            endcase
        end
    end

    // draw scaling: ceil(draw * total / 2^32) from two partial products
    assign low_sum = {1'b0, a_reg[7:0], rsp_pkg::HALF_W'(0)} + rsp_pkg::LOW_W'(b_reg);
    assign scaled  = a_reg[rsp_pkg::MUL_W-1:8]
                   + rsp_pkg::SUM_W'(low_sum[rsp_pkg::LOW_W-1:32])
                   + rsp_pkg::SUM_W'(low_sum[31:0] != '0);

    // one binary-search step per cycle on the registered read of mid
    assign ge      = (sum_rdata_reg >= target_reg);
    assign lo_step = ge ? lo_reg : mid_reg + rsp_pkg::IDX_W'(1);
    assign hi_step = ge ? mid_reg : hi_reg;
    assign span    = hi_step - lo_step;

    // perturb clamp, raise to pos_min first then lower to pos_max
    assign c_sum   = rsp_pkg::DATA_W'(signed'(coord_rdata_reg)) + 33'sd0
                   + (rsp_pkg::DATA_W+1)'(val_reg);
    assign c_low   = (c_sum < (rsp_pkg::DATA_W+1)'(pos_min_reg))
                   ? (rsp_pkg::DATA_W+1)'(pos_min_reg) : c_sum;
    assign c_clamp = (c_low > (rsp_pkg::DATA_W+1)'(pos_max_reg))
                   ? (rsp_pkg::DATA_W+1)'(pos_max_reg) : c_low;

    always_comb
    begin
        state_next        = state_reg;
        lc_next           = lc_reg;
        sel_next          = sel_reg;
        result_valid_next = result_valid_reg;
        lidx_next         = lidx_reg;
        val_next          = val_reg;
        draw_next         = draw_reg;
        total_next        = total_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        target_next       = target_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        pstat_next        = pstat_reg;
        pcoord_next       = pcoord_reg;

        sum_we      = 1'b0;
        sum_waddr   = sample_index;
        sum_wdata   = weight(value);
        sum_re      = 1'b0;
        sum_raddr   = sample_index - rsp_pkg::IDX_W'(1);
        coord_we    = 1'b0;
        coord_waddr = {sample_index, dim_index};
        coord_re    = 1'b0;
        coord_raddr = {sel_reg, dim_index};

        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    pstat_next  = rsp_pkg::STATUS_OK;
                    pcoord_next = '0;
                    val_next    = value;
                    draw_next   = draw;
                    lidx_next   = sample_index;
                    unique case (rsp_pkg::func_t'(func))
                        rsp_pkg::FUNC_LOAD:
                        begin
                            if (sample_index == '0)
                            begin
                                sum_we     = 1'b1;
                                lc_next    = rsp_pkg::CNT_W'(1);
                                state_next = ST_DONE;
                            end
                            else if (rsp_pkg::CNT_W'(sample_index) == lc_reg)
                            begin
                                sum_re     = 1'b1;
                                state_next = ST_LOAD;
                            end
                            else
                            begin
                                pstat_next = rsp_pkg::STATUS_ORDER;
                                state_next = ST_DONE;
                            end
                        end
                        rsp_pkg::FUNC_WRITE:
                        begin
                            coord_we   = 1'b1;
                            state_next = ST_DONE;
                        end
                        rsp_pkg::FUNC_DRAW:
                        begin
                            if (lc_reg == '0)
                            begin
                                pstat_next = rsp_pkg::STATUS_EMPTY;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                sum_re     = 1'b1;
                                sum_raddr  = lc_dec[rsp_pkg::IDX_W-1:0];
                                state_next = ST_MUL_HI;
                            end
                        end
                        rsp_pkg::FUNC_PERTURB:
                        begin
                            coord_re   = 1'b1;
                            state_next = ST_PERTURB;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD:
            begin
                sum_we     = 1'b1;
                sum_waddr  = lidx_reg;
                sum_wdata  = sum_rdata_reg + weight(val_reg);
                lc_next    = rsp_pkg::CNT_W'(lidx_reg) + rsp_pkg::CNT_W'(1);
                state_next = ST_DONE;
            end
            ST_MUL_HI:
            begin
                total_next = sum_rdata_reg;
                a_next     = rsp_pkg::MUL_W'(draw_reg)
                           * rsp_pkg::MUL_W'(sum_rdata_reg[rsp_pkg::SUM_W-1:rsp_pkg::HALF_W]);
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                b_next     = rsp_pkg::MUL_W'(draw_reg)
                           * rsp_pkg::MUL_W'(total_reg[rsp_pkg::HALF_W-1:0]);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                target_next = scaled;
                lo_next     = '0;
                hi_next     = lc_dec[rsp_pkg::IDX_W-1:0];
                mid_next    = lc_dec[rsp_pkg::IDX_W:1];
                if (lc_dec == '0)
                begin
                    sel_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    sum_re     = 1'b1;
                    sum_raddr  = lc_dec[rsp_pkg::IDX_W:1];
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                lo_next  = lo_step;
                hi_next  = hi_step;
                mid_next = lo_step + (span >> 1);
                if (lo_step < hi_step)
                begin
                    sum_re    = 1'b1;
                    sum_raddr = lo_step + (span >> 1);
                end
                else
                begin
                    sel_next   = lo_step;
                    state_next = ST_DONE;
                end
            end
            ST_PERTURB:
            begin
                pcoord_next = c_clamp[rsp_pkg::DATA_W-1:0];
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lc_reg           <= '0;
            sel_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            lc_reg           <= lc_next;
            sel_reg          <= sel_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lidx_reg   <= lidx_next;
        val_reg    <= val_next;
        draw_reg   <= draw_next;
        total_reg  <= total_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        target_reg <= target_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        pstat_reg  <= pstat_next;
        pcoord_reg <= pcoord_next;
        if (state_reg == ST_DONE && out_free)
        begin
            res_idx_reg   <= sel_reg;
            res_coord_reg <= pcoord_reg;
            res_stat_reg  <= pstat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sums_mem[sum_waddr] <= sum_wdata;
        if (sum_re)
            sum_rdata_reg <= sums_mem[sum_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (coord_we)
            coord_mem[coord_waddr] <= value;
        if (coord_re)
            coord_rdata_reg <= coord_mem[coord_raddr];
    end

    `RSP_ASSERT_NEXT(a_one_item, item_accept, !item_ready, "second item taken while busy")
    `RSP_ASSERT_NOW(a_search_bounds, state_reg == ST_SEARCH,
        lo_reg < hi_reg && rsp_pkg::CNT_W'(hi_reg) < lc_reg, "search window out of range")
    `RSP_ASSERT_NEXT(a_target_le_total, state_reg == ST_SCALE,
        target_reg <= total_reg, "scaled draw exceeds total weight")

endmodule

`default_nettype wire
